/* rtl/core/flc_pkg.sv */
// Shared types and constants for the free list coalescer.
package flc_pkg;

   localparam int FIELD_W        = 32;
   localparam int DEFAULT_DEPTH  = 32;
   localparam int DEFAULT_ADDR_W = 32;

   typedef enum logic [1:0] {
      REQ_ADD     = 2'd0,
      REQ_RELEASE = 2'd1,
      REQ_DUMP    = 2'd2
   } flc_req_type;

   typedef enum logic [2:0] {
      STAT_APPENDED     = 3'd0,
      STAT_INSERTED     = 3'd1,
      STAT_MERGED_LEFT  = 3'd2,
      STAT_MERGED_RIGHT = 3'd3,
      STAT_MERGED_BOTH  = 3'd4,
      STAT_TABLE_FULL   = 3'd5,
      STAT_DUMP_ENTRY   = 3'd6
   } flc_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_NEW_END,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_DECIDE,
      S_MERGE_R,
      S_MERGE_L,
      S_MERGE_B1,
      S_MERGE_B2,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_DUMP_RD,
      S_DUMP_GET,
      S_EMIT
   } flc_state_type;

   typedef struct packed {
      logic [FIELD_W-1:0] blk_len;
      logic [FIELD_W-1:0] blk_start;
   } flc_entry_type;

endpackage

/* rtl/core/flc_table.sv */
// Free block table storage: one write port, one registered read port.
module flc_table #(
   parameter int TABLE_DEPTH = flc_pkg::DEFAULT_DEPTH,
   parameter int IW          = $clog2(TABLE_DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IW-1:0]         wr_addr,
   input  flc_pkg::flc_entry_type wr_data,
   input  logic                  rd_en,
   input  logic [IW-1:0]         rd_addr,
   output flc_pkg::flc_entry_type rd_data
);

   flc_pkg::flc_entry_type mem [TABLE_DEPTH];
   flc_pkg::flc_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/free_list_coalescer_core.sv */
// Free list coalescer top level: free block table, ordered insert and merge on release.
//
// Keeps up to TABLE_DEPTH free blocks (start, length) in a table with one write
// port and one read port, and serves add, release and dump requests one at a
// time; req_tready is high only while the sequencer is idle. All end-address sums
// and saturating merges run through one 33-bit adder, which also feeds the left
// neighbor and insert point compares, and every table read goes through the one
// registered read port. A release scans the valid entries one by one, then moves
// every entry at and above the insert point for an insert, or every entry above
// the right neighbor that a double merge removes, besides the merge write. A dump
// reads and emits one entry at a time. Each result sits in an output register, so
// a stalled rsp side only holds the sequencer when a further result is ready to go
// out.
module free_list_coalescer_core #(
   parameter int TABLE_DEPTH = flc_pkg::DEFAULT_DEPTH,
   parameter int ADDR_WIDTH  = flc_pkg::DEFAULT_ADDR_W
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // blk_start[31:0], blk_size[63:32]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_start[31:0], out_size[63:32]
   output logic [3:0]  rsp_tuser,   // status[2:0], entry_valid[3]
   output logic        rsp_tlast    // last
);

   localparam int FW = flc_pkg::FIELD_W;
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [FW-1:0] IN_MASK   = (32'd1 << ADDR_WIDTH) - 32'd1;
   localparam logic [FW:0]   OVER_MASK = ~((33'd1 << ADDR_WIDTH) - 33'd1);
   localparam logic [CW-1:0] DEPTH_C   = CW'(TABLE_DEPTH);

   flc_pkg::flc_state_type  state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           pos_ff, pos_in;
   logic                    pos_hit_ff, pos_hit_in;
   logic                    shift_up_ff, shift_up_in;
   logic [FW-1:0]           s_ff, s_in;
   logic [FW-1:0]           l_ff, l_in;
   logic [FW:0]             enew_ff, enew_in;
   logic                    cnew_ff, cnew_in;
   logic [IW-1:0]           left_ff, left_in;
   logic [IW-1:0]           right_ff, right_in;
   logic                    left_hit_ff, left_hit_in;
   logic                    right_hit_ff, right_hit_in;
   logic [FW-1:0]           left_len_ff, left_len_in;
   logic [FW-1:0]           left_start_ff, left_start_in;
   logic [FW-1:0]           right_len_ff, right_len_in;
   logic [FW-1:0]           acc_ff, acc_in;

   flc_pkg::flc_status_type pend_status_ff, pend_status_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [FW-1:0]           pend_start_ff, pend_start_in;
   logic [FW-1:0]           pend_size_ff, pend_size_in;
   logic                    pend_last_ff, pend_last_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   flc_pkg::flc_status_type rsp_status_ff, rsp_status_in;
   logic                    rsp_evalid_ff, rsp_evalid_in;
   logic [FW-1:0]           rsp_start_ff, rsp_start_in;
   logic [FW-1:0]           rsp_size_ff, rsp_size_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    wr_en, rd_en;
   logic [IW-1:0]           wr_addr, rd_addr;
   flc_pkg::flc_entry_type  wr_data, rd_data;

   // shared adder
   logic [FW-1:0]           add_a, add_b;
   logic [FW:0]             add_sum;
   logic                    add_carry;
   logic [FW-1:0]           add_sat;

   logic [CW-1:0]           idx_up, idx_dn, pos_eff;
   logic                    right_eff;
   logic                    out_free;

   flc_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IW          (IW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign add_sum   = {1'b0, add_a} + {1'b0, add_b};
   assign add_carry = |(add_sum & OVER_MASK);
   assign add_sat   = add_sum[FW] ? '1 : add_sum[FW-1:0];

   assign idx_up    = idx_ff + CW'(1);
   assign idx_dn    = idx_ff - CW'(1);
   assign pos_eff   = pos_hit_ff ? pos_ff : count_ff;
   // a zero-length pair can hit the same entry on both sides: treat as left only
   assign right_eff = right_hit_ff && !(left_hit_ff && (left_ff == right_ff));
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flc_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      pos_ff         <= pos_in;
      pos_hit_ff     <= pos_hit_in;
      shift_up_ff    <= shift_up_in;
      s_ff           <= s_in;
      l_ff           <= l_in;
      enew_ff        <= enew_in;
      cnew_ff        <= cnew_in;
      left_ff        <= left_in;
      right_ff       <= right_in;
      left_hit_ff    <= left_hit_in;
      right_hit_ff   <= right_hit_in;
      left_len_ff    <= left_len_in;
      left_start_ff  <= left_start_in;
      right_len_ff   <= right_len_in;
      acc_ff         <= acc_in;
      pend_status_ff <= pend_status_in;
      pend_valid_ff  <= pend_valid_in;
      pend_start_ff  <= pend_start_in;
      pend_size_ff   <= pend_size_in;
      pend_last_ff   <= pend_last_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_evalid_ff  <= rsp_evalid_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_size_ff    <= rsp_size_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      pos_in         = pos_ff;
      pos_hit_in     = pos_hit_ff;
      shift_up_in    = shift_up_ff;
      s_in           = s_ff;
      l_in           = l_ff;
      enew_in        = enew_ff;
      cnew_in        = cnew_ff;
      left_in        = left_ff;
      right_in       = right_ff;
      left_hit_in    = left_hit_ff;
      right_hit_in   = right_hit_ff;
      left_len_in    = left_len_ff;
      left_start_in  = left_start_ff;
      right_len_in   = right_len_ff;
      acc_in         = acc_ff;
      pend_status_in = pend_status_ff;
      pend_valid_in  = pend_valid_ff;
      pend_start_in  = pend_start_ff;
      pend_size_in   = pend_size_ff;
      pend_last_in   = pend_last_ff;
      rsp_valid_in   = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_evalid_in  = rsp_evalid_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_size_in    = rsp_size_ff;
      rsp_last_in    = rsp_last_ff;
      req_tready     = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = idx_ff[IW-1:0];
      wr_data        = rd_data;
      rd_en          = 1'b0;
      rd_addr        = idx_ff[IW-1:0];
      add_a          = s_ff;
      add_b          = l_ff;

      unique case (state_ff)
         flc_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               s_in          = req_tdata[FW-1:0] & IN_MASK;
               l_in          = req_tdata[2*FW-1:FW];
               pend_valid_in = 1'b0;
               pend_start_in = '0;
               pend_size_in  = '0;
               pend_last_in  = 1'b1;
               idx_in        = '0;
               case (req_tuser)
                  flc_pkg::REQ_ADD: begin
                     if (count_ff == DEPTH_C) begin
                        pend_status_in = flc_pkg::STAT_TABLE_FULL;
                     end else begin
                        wr_en          = 1'b1;
                        wr_addr        = count_ff[IW-1:0];
                        wr_data        = '{blk_len: req_tdata[2*FW-1:FW],
                                           blk_start: req_tdata[FW-1:0] & IN_MASK};
                        count_in       = count_ff + CW'(1);
                        pend_status_in = flc_pkg::STAT_APPENDED;
                     end
                     state_in = flc_pkg::S_EMIT;
                  end
                  flc_pkg::REQ_RELEASE: begin
                     state_in = flc_pkg::S_NEW_END;
                  end
                  flc_pkg::REQ_DUMP: begin
                     if (count_ff == '0) begin
                        pend_status_in = flc_pkg::STAT_DUMP_ENTRY;
                        state_in       = flc_pkg::S_EMIT;
                     end else begin
                        state_in = flc_pkg::S_DUMP_RD;
                     end
                  end
                  default: begin
                     // unused request code: dropped, no result
                     state_in = flc_pkg::S_IDLE;
                  end
               endcase
            end
         end

         flc_pkg::S_NEW_END: begin
            enew_in      = add_sum;
            cnew_in      = add_carry;
            left_hit_in  = 1'b0;
            right_hit_in = 1'b0;
            pos_hit_in   = 1'b0;
            idx_in       = '0;
            state_in     = (count_ff == '0) ? flc_pkg::S_DECIDE : flc_pkg::S_SCAN_RD;
         end

         flc_pkg::S_SCAN_RD: begin
            rd_en    = 1'b1;
            state_in = flc_pkg::S_SCAN_CMP;
         end

         flc_pkg::S_SCAN_CMP: begin
            add_a = rd_data.blk_start;
            add_b = rd_data.blk_len;
            // later matches overwrite: highest index wins
            if (!cnew_ff && ({1'b0, rd_data.blk_start} == enew_ff)) begin
               right_hit_in = 1'b1;
               right_in     = idx_ff[IW-1:0];
               right_len_in = rd_data.blk_len;
            end
            if (!add_carry && (add_sum == {1'b0, s_ff})) begin
               left_hit_in   = 1'b1;
               left_in       = idx_ff[IW-1:0];
               left_len_in   = rd_data.blk_len;
               left_start_in = rd_data.blk_start;
            end
            if (!pos_hit_ff && (add_carry || (add_sum >= {1'b0, s_ff}))) begin
               pos_hit_in = 1'b1;
               pos_in     = idx_ff;
            end
            idx_in   = idx_up;
            state_in = (idx_up < count_ff) ? flc_pkg::S_SCAN_RD : flc_pkg::S_DECIDE;
         end

         flc_pkg::S_DECIDE: begin
            if (!left_hit_ff && !right_eff) begin
               if (count_ff == DEPTH_C) begin
                  pend_status_in = flc_pkg::STAT_TABLE_FULL;
                  state_in       = flc_pkg::S_EMIT;
               end else begin
                  pend_status_in = flc_pkg::STAT_INSERTED;
                  idx_in         = count_ff;
                  pos_in         = pos_eff;
                  shift_up_in    = 1'b1;
                  state_in       = (pos_eff < count_ff) ? flc_pkg::S_SHIFT_RD
                                                        : flc_pkg::S_PLACE;
               end
            end else if (!left_hit_ff) begin
               state_in = flc_pkg::S_MERGE_R;
            end else if (!right_eff) begin
               state_in = flc_pkg::S_MERGE_L;
            end else begin
               state_in = flc_pkg::S_MERGE_B1;
            end
         end

         flc_pkg::S_MERGE_R: begin
            add_a          = right_len_ff;
            add_b          = l_ff;
            wr_en          = 1'b1;
            wr_addr        = right_ff;
            wr_data        = '{blk_len: add_sat, blk_start: s_ff};
            pend_status_in = flc_pkg::STAT_MERGED_RIGHT;
            state_in       = flc_pkg::S_EMIT;
         end

         flc_pkg::S_MERGE_L: begin
            add_a          = left_len_ff;
            add_b          = l_ff;
            wr_en          = 1'b1;
            wr_addr        = left_ff;
            wr_data        = '{blk_len: add_sat, blk_start: left_start_ff};
            pend_status_in = flc_pkg::STAT_MERGED_LEFT;
            state_in       = flc_pkg::S_EMIT;
         end

         flc_pkg::S_MERGE_B1: begin
            add_a    = left_len_ff;
            add_b    = l_ff;
            acc_in   = add_sat;
            state_in = flc_pkg::S_MERGE_B2;
         end

         flc_pkg::S_MERGE_B2: begin
            add_a          = acc_ff;
            add_b          = right_len_ff;
            wr_en          = 1'b1;
            wr_addr        = left_ff;
            wr_data        = '{blk_len: add_sat, blk_start: left_start_ff};
            pend_status_in = flc_pkg::STAT_MERGED_BOTH;
            count_in       = count_ff - CW'(1);
            idx_in         = CW'(right_ff);
            shift_up_in    = 1'b0;
            // close the gap left by the right entry
            state_in       = (CW'(right_ff) < count_in) ? flc_pkg::S_SHIFT_RD
                                                        : flc_pkg::S_EMIT;
         end

         flc_pkg::S_SHIFT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = shift_up_ff ? idx_dn[IW-1:0] : idx_up[IW-1:0];
            state_in = flc_pkg::S_SHIFT_WR;
         end

         flc_pkg::S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IW-1:0];
            wr_data = rd_data;
            if (shift_up_ff) begin
               idx_in   = idx_dn;
               state_in = (idx_dn > pos_ff) ? flc_pkg::S_SHIFT_RD : flc_pkg::S_PLACE;
            end else begin
               idx_in   = idx_up;
               state_in = (idx_up < count_ff) ? flc_pkg::S_SHIFT_RD : flc_pkg::S_EMIT;
            end
         end

         flc_pkg::S_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[IW-1:0];
            wr_data  = '{blk_len: l_ff, blk_start: s_ff};
            count_in = count_ff + CW'(1);
            state_in = flc_pkg::S_EMIT;
         end

         flc_pkg::S_DUMP_RD: begin
            rd_en    = 1'b1;
            state_in = flc_pkg::S_DUMP_GET;
         end

         flc_pkg::S_DUMP_GET: begin
            pend_status_in = flc_pkg::STAT_DUMP_ENTRY;
            pend_valid_in  = 1'b1;
            pend_start_in  = rd_data.blk_start;
            pend_size_in   = rd_data.blk_len;
            pend_last_in   = (idx_up == count_ff);
            idx_in         = idx_up;
            state_in       = flc_pkg::S_EMIT;
         end

         flc_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_evalid_in = pend_valid_ff;
               rsp_start_in  = pend_start_ff;
               rsp_size_in   = pend_size_ff;
               rsp_last_in   = pend_last_ff;
               state_in      = pend_last_ff ? flc_pkg::S_IDLE : flc_pkg::S_DUMP_RD;
            end
         end

         default: begin
            state_in = flc_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_size_ff, rsp_start_ff};
   assign rsp_tuser  = {rsp_evalid_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("free count beyond table depth");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == flc_pkg::REQ_ADD) && (count_ff != DEPTH_C))
      |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("add did not grow the table");

   a_single_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[2:0] != flc_pkg::STAT_DUMP_ENTRY))
      |-> (rsp_tlast && !rsp_tuser[3]))
      else $error("non-dump result not a single last word");

   a_wr_addr: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) < DEPTH_C))
      else $error("table write beyond depth");

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == flc_pkg::S_EMIT) |-> !req_tready)
      else $error("ready while a result is pending");
`endif

endmodule
